// File: design/pas_pkg.sv
`timescale 1ns / 1ps
package pas_pkg;

	typedef enum logic [1:0] {
		OP_POINT_WRITE = 2'd0,
		OP_RANGE_WRITE = 2'd1,
		OP_POINT_READ  = 2'd2,
		OP_NONE        = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_READ
	} state_t;

	localparam logic [31:0] RESET_START = 32'h0000_0000;
	localparam logic [31:0] RESET_DIST  = 32'hFFFF_FFFF;
	localparam int unsigned ENTRY_W     = 64;

endpackage

// File: design/pas_req_if.sv
`timescale 1ns / 1ps
interface pas_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [9:0]         index_lo;
	logic [10:0]        index_hi;
	logic signed [31:0] first_value;
	logic signed [31:0] first_dist;

	modport source (output valid, op, index_lo, index_hi, first_value, first_dist,
		input ready);
	modport sink (input valid, op, index_lo, index_hi, first_value, first_dist,
		output ready);
endinterface

// File: design/pas_rsp_if.sv
`timescale 1ns / 1ps
interface pas_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic signed [31:0] read_dist;

	modport source (output valid, read_value, read_dist, input ready);
	modport sink (input valid, read_value, read_dist, output ready);
endinterface

// File: design/pas_ram.sv
`timescale 1ns / 1ps
module pas_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/progression_assign_segment_table_top.sv
`timescale 1ns / 1ps
// Point write: written to the RAM in the cycle it is accepted; next word taken in the following cycle.
// Point read: the word passes the registered RAM read, then the output register; next word
// taken once the word is loaded into the output register, which waits while it is stalled.
// Range write: fills entries lo to hi - 1 (hi clipped to CAPACITY) after acceptance, one entry per cycle;
// next word taken when the fill ends (in the following cycle for an empty range).
// Reset: asynchronous, active low; a clearing pass writes (0, -1) to every entry, req.ready low.
module progression_assign_segment_table_top #(
	parameter int CAPACITY = 1024
) (
	input  logic clk,
	input  logic arst_n,
	pas_req_if.sink   req,
	pas_rsp_if.source rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [16:0] CAP17 = 17'(CAPACITY);

	pas_pkg::state_t state_q, state_d;

	logic [CW-1:0] ptr_q, end_q;
	logic [31:0]   s_q, d_q;
	logic          oor_q;
	logic          rsp_valid_q;
	logic [31:0]   rsp_value_q, rsp_dist_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [pas_pkg::ENTRY_W-1:0] wdata, rdata;

	logic [16:0]   lo17, hi17, hic17;
	logic          lo_ok, range_ok, accept, load_rsp, fill_last, clear_last;

	assign lo17     = 17'(req.index_lo);
	assign hi17     = 17'(req.index_hi);
	assign hic17    = (hi17 > CAP17) ? CAP17 : hi17;
	assign lo_ok    = lo17 < CAP17;
	assign range_ok = lo17 < hic17;
	assign accept   = req.valid && req.ready;
	assign load_rsp = !rsp_valid_q || rsp.ready;
	assign fill_last  = (ptr_q + CW'(1)) == end_q;
	assign clear_last = ptr_q == CW'(CAPACITY - 1);

	pas_ram #(.WIDTH(pas_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pas_pkg::ST_CLEAR: begin
				if (clear_last) state_d = pas_pkg::ST_IDLE;
			end
			pas_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.op == pas_pkg::OP_RANGE_WRITE && range_ok) begin
						state_d = pas_pkg::ST_FILL;
					end else if (req.op == pas_pkg::OP_POINT_READ) begin
						state_d = pas_pkg::ST_READ;
					end
				end
			end
			pas_pkg::ST_FILL: begin
				if (fill_last) state_d = pas_pkg::ST_IDLE;
			end
			pas_pkg::ST_READ: begin
				if (load_rsp) state_d = pas_pkg::ST_IDLE;
			end
			default: state_d = pas_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		we    = 1'b0;
		waddr = ptr_q[AW-1:0];
		wdata = {pas_pkg::RESET_START, pas_pkg::RESET_DIST};
		re    = 1'b0;
		raddr = lo17[AW-1:0];
		case (state_q)
			pas_pkg::ST_CLEAR: begin
				we = 1'b1;
			end
			pas_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.op == pas_pkg::OP_POINT_WRITE && lo_ok) begin
					we    = 1'b1;
					waddr = lo17[AW-1:0];
					wdata = {req.first_value, req.first_dist};
				end
				re = req.valid && req.op == pas_pkg::OP_POINT_READ;
			end
			pas_pkg::ST_FILL: begin
				we    = 1'b1;
				wdata = {s_q, d_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pas_pkg::ST_CLEAR;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pas_pkg::ST_CLEAR: ptr_q <= ptr_q + CW'(1);
				pas_pkg::ST_IDLE:  ptr_q <= lo17[CW-1:0];
				pas_pkg::ST_FILL:  ptr_q <= ptr_q + CW'(1);
				default: ;
			endcase
			if (state_q == pas_pkg::ST_READ && load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pas_pkg::ST_IDLE && accept) begin
			end_q <= hic17[CW-1:0];
			s_q   <= req.first_value;
			d_q   <= req.first_dist;
			oor_q <= !lo_ok;
		end else if (state_q == pas_pkg::ST_FILL) begin
			s_q <= s_q + 32'd1;
			d_q <= d_q - 32'd1;
		end
		if (state_q == pas_pkg::ST_READ && load_rsp) begin
			rsp_value_q <= oor_q ? pas_pkg::RESET_START : rdata[63:32];
			rsp_dist_q  <= oor_q ? pas_pkg::RESET_DIST  : rdata[31:0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.read_dist  = rsp_dist_q;
endmodule

// File: design/pas_checker.sv
`timescale 1ns / 1ps
module pas_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_op,
	input logic       rsp_valid,
	input logic       rsp_ready
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp word dropped while stalled");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == pas_pkg::OP_POINT_READ |=> !req_ready)
		else $error("req taken during read");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("rsp word without a read");
endmodule

bind progression_assign_segment_table_top pas_checker u_pas_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .req_op(req.op),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);
